// ===== rtl/ist_pkg.sv =====
// Package for the integer set table: operation codes and default sizing.
// Used by integer_set_table_unit; depends on nothing else.
package ist_pkg;

  localparam int IST_CAPACITY = 16;
  localparam int IST_VALUE_W = 32;
  localparam int IST_COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } ist_op_t;

endpackage

// ===== rtl/integer_set_table_unit.sv =====
// Integer set table: a packed table of distinct 32-bit values with an entry count,
// scanned and compacted one entry per cycle through a memory with separate read and write ports.
// Depends on ist_pkg.
//
//   channel  direction  tdata                         tuser
//   in_      slave      [31:0] value                  [1:0] mode
//   out_     master     [0] success, [1] full_reject, none
//                       [6:2] entry_count, [7] is_empty
//
// Clear goes straight to its result item. Find and insert read the entries in order
// until a match is found or the entry count is reached.
// Erase with a match then compacts the table, moving each later entry down one place.
// The memory read port delivers one entry per cycle to the scan and the compaction.
// Reset clears the state, the count and the pending flag; the memory keeps no reset value.
// in_tready is low from acceptance until the result item is taken on out_.

module integer_set_table_unit
  import ist_pkg::*;
#(
  parameter int CAPACITY = IST_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IST_VALUE_W-1:0] in_tdata,   // [31:0] value
  input  logic [1:0]             in_tuser,   // [1:0] mode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata   // success, full_reject, entry_count, is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic                   pend_r, pend_nxt;
  logic [AW-1:0]          pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]          wr_idx_r, wr_idx_nxt;
  logic [IST_VALUE_W-1:0] key_r, key_nxt;
  ist_op_t                op_r, op_nxt;
  logic                   succ_r, succ_nxt;
  logic                   rej_r, rej_nxt;

  logic [IST_VALUE_W-1:0] mem [CAPACITY];
  logic [IST_VALUE_W-1:0] rd_data_r;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [IST_VALUE_W-1:0] wd;
  logic                   hit;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_RESP);
  assign out_tdata  = {(count_r == '0), IST_COUNT_OUT_W'(count_r), rej_r, succ_r};
  assign hit        = pend_r && (rd_data_r == key_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    wr_idx_nxt   = wr_idx_r;
    key_nxt      = key_r;
    op_nxt       = op_r;
    succ_nxt     = succ_r;
    rej_nxt      = rej_r;
    rd_addr      = idx_r[AW-1:0];
    we           = 1'b0;
    wa           = wr_idx_r;
    wd           = rd_data_r;
    case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (in_tvalid) begin
          key_nxt = in_tdata;
          op_nxt  = ist_op_t'(in_tuser);
          rej_nxt = 1'b0;
          if (ist_op_t'(in_tuser) == OP_CLEAR) begin
            count_nxt = '0;
            succ_nxt  = 1'b1;
            state_nxt = ST_RESP;
          end else begin
            idx_nxt      = CW'(1);
            pend_nxt     = (count_r != '0);
            pend_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || !pend_r) begin
          state_nxt = ST_RESP;
          succ_nxt  = 1'b0;
          rej_nxt   = 1'b0;
          case (op_r)
            OP_FIND: begin
              succ_nxt = hit;
            end
            OP_INSERT: begin
              if (!hit) begin
                if (count_r == CW'(CAPACITY)) begin
                  rej_nxt = 1'b1;
                end else begin
                  we        = 1'b1;
                  wa        = count_r[AW-1:0];
                  wd        = key_r;
                  count_nxt = count_r + CW'(1);
                  succ_nxt  = 1'b1;
                end
              end
            end
            OP_ERASE: begin
              if (hit) begin
                succ_nxt   = 1'b1;
                wr_idx_nxt = pend_idx_r;
                idx_nxt    = CW'(pend_idx_r) + CW'(1);
                pend_nxt   = 1'b0;
                state_nxt  = ST_SHIFT;
              end
            end
            default: begin
              succ_nxt  = 1'b1;
              count_nxt = '0;
            end
          endcase
        end else begin
          pend_nxt     = (idx_r < count_r);
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + CW'(1);
        end
      end
      ST_SHIFT: begin
        if (pend_r) begin
          we         = 1'b1;
          wa         = wr_idx_r;
          wd         = rd_data_r;
          wr_idx_nxt = wr_idx_r + AW'(1);
        end
        if (idx_r < count_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    key_r      <= key_nxt;
    op_r       <= op_nxt;
    succ_r     <= succ_nxt;
    rej_r      <= rej_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && rej_r) |-> (count_r == CW'(CAPACITY) && !succ_r))
    else $error("insert rejected while table not full");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SHIFT) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1) ||
       count_r == $past(count_r) - CW'(1)))
    else $error("entry count changed by more than one during an operation");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_RESP && op_r == OP_INSERT && succ_nxt) |=>
      (count_r == $past(count_r) + CW'(1)))
    else $error("successful insert did not grow the table");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for integer_set_table_unit: drives find, insert, erase and
// clear items on the input stream and checks every result item against a mirror set.
// Depends on ist_pkg and the RTL of integer_set_table_unit only.

module tb_top;
  import ist_pkg::*;

  localparam int CAP = IST_CAPACITY;
  localparam int POOL_SIZE = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 550;
  localparam int SEGMENT_ITEMS = 50;

  typedef logic [IST_VALUE_W-1:0] value_t;

  typedef struct packed {
    logic       is_empty;
    logic [4:0] entry_count;
    logic       full_reject;
    logic       success;
  } set_result_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  value_t       in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;

  value_t       set_mirror [CAP];
  int           mirror_count = 0;
  value_t       value_pool [POOL_SIZE];
  set_result_t  pending_results [$];
  int           mismatches = 0;
  int unsigned  burst_left = 0;
  bit           hold_off_req = 1'b0;

  integer_set_table_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int find_pos(value_t value);
    for (int i = 0; i < mirror_count; i++) begin
      if (set_mirror[i] == value) begin
        return i;
      end
    end
    return mirror_count;
  endfunction

  function automatic set_result_t apply_set_op(ist_op_t op, value_t value);
    set_result_t r;
    int pos;
    r = '0;
    pos = find_pos(value);
    case (op)
      OP_FIND: begin
        r.success = (pos < mirror_count);
      end
      OP_INSERT: begin
        if (pos == mirror_count) begin
          if (mirror_count >= CAP) begin
            r.full_reject = 1'b1;
          end else begin
            set_mirror[mirror_count] = value;
            mirror_count++;
            r.success = 1'b1;
          end
        end
      end
      OP_ERASE: begin
        if (pos < mirror_count) begin
          for (int i = pos; i + 1 < mirror_count; i++) begin
            set_mirror[i] = set_mirror[i + 1];
          end
          mirror_count--;
          r.success = 1'b1;
        end
      end
      default: begin
        mirror_count = 0;
        r.success = 1'b1;
      end
    endcase
    r.entry_count = 5'(mirror_count);
    r.is_empty = (mirror_count == 0);
    return r;
  endfunction

  function automatic value_t fresh_value();
    value_t v;
    do begin
      v = $urandom;
    end while (find_pos(v) < mirror_count);
    return v;
  endfunction

  task automatic send_item(input ist_op_t op, input value_t value);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_set_op(op, value));
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      in_tdata <= $urandom;
      in_tuser <= 2'($urandom_range(0, 3));
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
  endtask

  task automatic send_random_item(input int insert_weight);
    int unsigned roll;
    ist_op_t op;
    value_t value;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      op = OP_CLEAR;
    end else if (roll < 2 + insert_weight) begin
      op = OP_INSERT;
    end else if (roll < 32 + insert_weight) begin
      op = OP_FIND;
    end else begin
      op = OP_ERASE;
    end
    if ($urandom_range(0, 9) == 0) begin
      value = $urandom;
    end else begin
      value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    send_item(op, value);
  endtask

  task automatic test_empty_table();
    send_item(OP_FIND, 32'h1234_5678);
    send_item(OP_ERASE, 32'h1234_5678);
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
  endtask

  task automatic test_extreme_values();
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_FIND, 32'hFFFF_FFFF);
    send_item(OP_FIND, 32'h0000_0001);
  endtask

  task automatic test_erase_positions();
    send_item(OP_ERASE, 32'h0000_0000);
    send_item(OP_ERASE, 32'h8000_0000);
    send_item(OP_ERASE, 32'hFFFF_FFFF);
    send_item(OP_ERASE, 32'h0000_0000);
  endtask

  task automatic test_full_table();
    while (mirror_count < CAP) begin
      send_item(OP_INSERT, fresh_value());
    end
    send_item(OP_INSERT, fresh_value());
    send_item(OP_INSERT, set_mirror[CAP - 1]);
    send_item(OP_CLEAR, $urandom);
  endtask

  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (8) send_random_item(60);
    wait_for_results();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_random_item(((i / SEGMENT_ITEMS) % 2 == 0) ? 55 : 20);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_FIND;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (value_pool[i]) begin
      value_pool[i] = $urandom;
    end
    test_empty_table();
    test_extreme_values();
    test_erase_positions();
    test_full_table();
    test_backpressure();
    test_random_mix();
    wait_for_results();
    repeat (48) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // The receiver mixes steady, random and fully stalled stretches, and honors one
  // long hold-off when the back-pressure test asks for it.
  initial begin
    int unsigned span;
    int unsigned style;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(4, 40);
        style = $urandom_range(0, 3);
        for (int i = 0; i < span; i++) begin
          case (style)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'b0;
            default: out_tready <= ($urandom_range(0, 2) != 0);
          endcase
          @(posedge clk);
          if (hold_off_req) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    set_result_t got;
    set_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = set_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result item with none expected:", $time);
        $display("%0t: actual   success=%b full_reject=%b count=%0d empty=%b",
                 $time, got.success, got.full_reject, got.entry_count, got.is_empty);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected success=%b full_reject=%b count=%0d empty=%b",
                   $time, want.success, want.full_reject, want.entry_count, want.is_empty);
          $display("%0t: actual   success=%b full_reject=%b count=%0d empty=%b",
                   $time, got.success, got.full_reject, got.entry_count, got.is_empty);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
